// ===== rtl/uipp_pkg.sv =====
// Shared constants, codes and sequencer states of the write placement engine.
package uipp_pkg;

    localparam int SLOTS_DEF           = 64;
    localparam int PAGES_PER_BLOCK_DEF = 64;
    localparam int LOGICAL_PAGES_DEF   = 4096;
    localparam int FRACTION_BITS_DEF   = 8;

    localparam int COUNT_W   = 16;
    localparam int VALID_W   = 7;
    localparam int VALID_MAX = 127;
    localparam int DIVISOR_W = 16;
    localparam int PAGE_IN_W = 12;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] STAT_PLACED   = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
    localparam logic [1:0] STAT_RELEASED = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_MOD_FIN,
        ST_PAGE_RD,
        ST_FULL,
        ST_AVG,
        ST_AVG_FIN,
        ST_SCAN,
        ST_P_RD,
        ST_P_WAIT,
        ST_P_MUL,
        ST_P_CMP,
        ST_P_DIV,
        ST_P_WR,
        ST_A_RD,
        ST_A_WAIT,
        ST_A_MUL,
        ST_A_SUM,
        ST_A_DIV,
        ST_A_WR,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/uipp_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module uipp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/update_interval_page_placement_core.sv =====
// Flash write placement engine: page interval tracking and nearest-slot selection.
//
// Input words arrive on the s_axis group: s_axis_tuser carries the opcode (write or
// release), s_axis_tdata the page, the write time and the slot to release. Every
// input word yields exactly one result word on the m_axis group: m_axis_tuser holds
// the status, m_axis_tdata the chosen location, the new-block flag and the old copy.
// The engine works on one word at a time. A release goes from acceptance straight to
// the done state. A write makes one pass over the slot table to look for room, one
// pass that ages every slot and picks the nearest one, and up to three divisions on a
// shared restoring divider that retires one quotient bit per cycle. A refused write
// ends after the first pass. When LOGICAL_PAGES is below 4096 the page number is first
// reduced on the same divider.
// After reset the engine clears the page and slot tables, one entry per cycle, and
// holds s_axis_tready low meanwhile.
// A finished result waits in the output register while the receiver stalls; the next
// word is accepted meanwhile, but its result waits until the register is free.
module update_interval_page_placement_core #(
    parameter int SLOTS           = uipp_pkg::SLOTS_DEF,
    parameter int PAGES_PER_BLOCK = uipp_pkg::PAGES_PER_BLOCK_DEF,
    parameter int LOGICAL_PAGES   = uipp_pkg::LOGICAL_PAGES_DEF,
    parameter int FRACTION_BITS   = uipp_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] logical_page, [43:12] now_time, [49:44] release_slot, [55:50] zero
    input  logic [55:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] chosen_slot, [11:6] chosen_offset, [12] need_new_block, [13] old_valid,
    // [19:14] old_slot, [25:20] old_offset, [31:26] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    localparam int TW    = 32 + FRACTION_BITS;
    localparam int VW    = uipp_pkg::VALID_W;
    localparam int CW    = uipp_pkg::COUNT_W;
    localparam int DVW   = uipp_pkg::DIVISOR_W;
    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = $clog2(LOGICAL_PAGES);
    localparam int FW    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int DN    = TW + VW + 1;
    localparam int DCW   = $clog2(DN);
    localparam int PRW   = TW + VW;
    localparam int SLW   = TW + VW + FW + 1;
    localparam int PSW   = TW + 32 + CW;
    localparam int LCW   = SW + FW;
    localparam int CLR_N = (LOGICAL_PAGES > SLOTS) ? LOGICAL_PAGES : SLOTS;
    localparam int CLW   = $clog2(CLR_N + 1);
    localparam bit MOD_PAGE = LOGICAL_PAGES < 4096;
    localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
    localparam logic [FW-1:0] PPB_F    = FW'(PAGES_PER_BLOCK);
    localparam logic [VW-1:0] VMAX_F   = VW'(uipp_pkg::VALID_MAX);
    localparam logic [CW-1:0] CMAX_F   = {CW{1'b1}};

    uipp_pkg::state_t state_reg, state_next;

    // input capture
    logic [PW-1:0] lp_reg;
    logic [31:0]   now_reg;
    logic [31:0]   last_time_reg;

    // page record of the current word
    logic [CW-1:0] cnt_old_reg;
    logic [31:0]   first_reg;
    logic [SW-1:0] prev_slot_reg;
    logic [FW-1:0] prev_off_reg;
    logic [TW-1:0] amt_reg;
    logic [TW-1:0] gap_reg;

    // scan
    logic [SW:0]   k_reg;
    logic          any_reg;
    logic          found_reg;
    logic [SW-1:0] best_reg;
    logic [TW-1:0] best_d_reg;
    logic [FW-1:0] best_fill_reg;
    logic          best_hb_reg;

    // slot entry being corrected
    logic [TW-1:0]  ent_e_reg;
    logic [VW-1:0]  ent_v_reg;
    logic [FW-1:0]  ent_fill_reg;
    logic           ent_hb_reg;
    logic [TW-1:0]  pe_reg;
    logic           use_div_reg;
    logic [PRW-1:0] prod_reg;

    // shared divider
    logic [DN-1:0]  dq_reg;
    logic [DVW-1:0] drem_reg;
    logic [DVW-1:0] ddiv_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           div_load;
    logic [DN-1:0]  div_dividend;
    logic [DVW-1:0] div_divisor;
    logic           div_run;
    logic           div_last;
    logic [DVW:0]   div_trial;
    logic           div_ge;
    logic [TW-1:0]  dq_sat;

    // clearing pass
    logic [CLW-1:0] clr_reg;

    // result staging and output register
    logic [1:0]    res_status_reg;
    logic [5:0]    res_slot_reg;
    logic [5:0]    res_off_reg;
    logic          res_need_reg;
    logic          res_old_v_reg;
    logic [5:0]    res_old_slot_reg;
    logic [5:0]    res_old_off_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [25:0]   out_data_reg;

    // memories
    logic           ps_we;
    logic [PW-1:0]  ps_waddr;
    logic [PSW-1:0] ps_wdata;
    logic [PSW-1:0] ps_rdata;
    logic           pl_we;
    logic [LCW-1:0] pl_wdata;
    logic [LCW-1:0] pl_rdata;
    logic           sl_we;
    logic [SW-1:0]  sl_waddr;
    logic [SLW-1:0] sl_wdata;
    logic [SW-1:0]  sl_raddr;
    logic [SLW-1:0] sl_rdata;

    // input fields
    logic          in_op;
    logic [11:0]   in_page;
    logic [31:0]   in_now;
    logic [5:0]    in_rs;
    logic [SW+6:0] in_rs_w;
    logic          in_acc;
    logic          rs_ok;

    // slot read fields
    logic [TW-1:0] sd_e;
    logic [VW-1:0] sd_v;
    logic [FW-1:0] sd_fill;
    logic          sd_hb;
    logic [TW-1:0] aged;
    logic [TW-1:0] slot_dist;
    logic          sd_open;
    logic [SW:0]   km1;

    logic [CW-1:0] cnt_new;
    logic [31:0]   first_new;
    logic [31:0]   span;
    logic [31:0]   elapsed;
    logic [TW-1:0] pe_new;

    assign in_op   = s_axis_tuser;
    assign in_page = s_axis_tdata[11:0];
    assign in_now  = s_axis_tdata[43:12];
    assign in_rs   = s_axis_tdata[49:44];
    assign in_rs_w = (SW + 7)'(in_rs);
    assign rs_ok   = in_rs_w < (SW + 7)'(SLOTS);
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign sd_hb     = sl_rdata[0];
    assign sd_fill   = sl_rdata[FW:1];
    assign sd_v      = sl_rdata[FW+VW:FW+1];
    assign sd_e      = sl_rdata[SLW-1:FW+VW+1];
    assign aged      = (sd_e < gap_reg) ? '0 : sd_e - gap_reg;
    assign slot_dist = (amt_reg > aged) ? amt_reg - aged : aged - amt_reg;
    assign sd_open   = sd_fill < PPB_F;
    assign km1       = k_reg - 1'b1;

    assign cnt_new   = (cnt_old_reg == CMAX_F) ? cnt_old_reg : cnt_old_reg + 1'b1;
    assign first_new = (cnt_old_reg == '0) ? now_reg : first_reg;
    assign span      = (now_reg > first_reg) ? now_reg - first_reg : 32'd0;
    assign elapsed   = (now_reg > last_time_reg) ? now_reg - last_time_reg : 32'd0;

    assign div_run   = (state_reg == uipp_pkg::ST_MOD) || (state_reg == uipp_pkg::ST_AVG) ||
                       (state_reg == uipp_pkg::ST_P_DIV) || (state_reg == uipp_pkg::ST_A_DIV);
    assign div_last  = dcnt_reg == DCW'(DN - 1);
    assign div_trial = {drem_reg, dq_reg[DN-1]};
    assign div_ge    = div_trial >= {1'b0, ddiv_reg};
    assign dq_sat    = (dq_reg[DN-1:TW] != '0) ? TIME_MAX : dq_reg[TW-1:0];
    assign pe_new    = use_div_reg ? dq_sat : pe_reg;

    uipp_ram #(.W(PSW), .D(LOGICAL_PAGES)) u_page_stat (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (lp_reg),
        .rdata (ps_rdata)
    );

    uipp_ram #(.W(LCW), .D(LOGICAL_PAGES)) u_page_loc (
        .clk   (clk),
        .we    (pl_we),
        .waddr (lp_reg),
        .wdata (pl_wdata),
        .raddr (lp_reg),
        .rdata (pl_rdata)
    );

    uipp_ram #(.W(SLW), .D(SLOTS)) u_slot (
        .clk   (clk),
        .we    (sl_we),
        .waddr (sl_waddr),
        .wdata (sl_wdata),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uipp_pkg::ST_CLEAR:
            begin
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = uipp_pkg::ST_IDLE;
                end
            end
            uipp_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_op == uipp_pkg::OP_RELEASE)
                    begin
                        state_next = uipp_pkg::ST_DONE;
                    end
                    else if (MOD_PAGE)
                    begin
                        state_next = uipp_pkg::ST_MOD;
                    end
                    else
                    begin
                        state_next = uipp_pkg::ST_PAGE_RD;
                    end
                end
            end
            uipp_pkg::ST_MOD:
            begin
                if (div_last)
                begin
                    state_next = uipp_pkg::ST_MOD_FIN;
                end
            end
            uipp_pkg::ST_MOD_FIN:
            begin
                state_next = uipp_pkg::ST_PAGE_RD;
            end
            uipp_pkg::ST_PAGE_RD:
            begin
                state_next = uipp_pkg::ST_FULL;
            end
            uipp_pkg::ST_FULL:
            begin
                if (k_reg == (SW + 1)'(SLOTS))
                begin
                    if (!(any_reg || sd_open))
                    begin
                        state_next = uipp_pkg::ST_DONE;
                    end
                    else if (cnt_old_reg != '0)
                    begin
                        state_next = uipp_pkg::ST_AVG;
                    end
                    else
                    begin
                        state_next = uipp_pkg::ST_SCAN;
                    end
                end
            end
            uipp_pkg::ST_AVG:
            begin
                if (div_last)
                begin
                    state_next = uipp_pkg::ST_AVG_FIN;
                end
            end
            uipp_pkg::ST_AVG_FIN:
            begin
                state_next = uipp_pkg::ST_SCAN;
            end
            uipp_pkg::ST_SCAN:
            begin
                if (k_reg == (SW + 1)'(SLOTS))
                begin
                    state_next = (cnt_old_reg != '0) ? uipp_pkg::ST_P_RD : uipp_pkg::ST_A_RD;
                end
            end
            uipp_pkg::ST_P_RD:
            begin
                state_next = uipp_pkg::ST_P_WAIT;
            end
            uipp_pkg::ST_P_WAIT:
            begin
                if ((cnt_old_reg > CW'(1)) && (sd_v > VW'(1)))
                begin
                    state_next = uipp_pkg::ST_P_MUL;
                end
                else
                begin
                    state_next = uipp_pkg::ST_P_WR;
                end
            end
            uipp_pkg::ST_P_MUL:
            begin
                state_next = uipp_pkg::ST_P_CMP;
            end
            uipp_pkg::ST_P_CMP:
            begin
                if (prod_reg < PRW'(amt_reg))
                begin
                    state_next = uipp_pkg::ST_P_WR;
                end
                else
                begin
                    state_next = uipp_pkg::ST_P_DIV;
                end
            end
            uipp_pkg::ST_P_DIV:
            begin
                if (div_last)
                begin
                    state_next = uipp_pkg::ST_P_WR;
                end
            end
            uipp_pkg::ST_P_WR:
            begin
                state_next = uipp_pkg::ST_A_RD;
            end
            uipp_pkg::ST_A_RD:
            begin
                state_next = uipp_pkg::ST_A_WAIT;
            end
            uipp_pkg::ST_A_WAIT:
            begin
                state_next = (cnt_old_reg != '0) ? uipp_pkg::ST_A_MUL : uipp_pkg::ST_A_WR;
            end
            uipp_pkg::ST_A_MUL:
            begin
                state_next = uipp_pkg::ST_A_SUM;
            end
            uipp_pkg::ST_A_SUM:
            begin
                state_next = uipp_pkg::ST_A_DIV;
            end
            uipp_pkg::ST_A_DIV:
            begin
                if (div_last)
                begin
                    state_next = uipp_pkg::ST_A_WR;
                end
            end
            uipp_pkg::ST_A_WR:
            begin
                state_next = uipp_pkg::ST_DONE;
            end
            uipp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = uipp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uipp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Memory ports, divider loading and handshake.
    always_comb
    begin
        s_axis_tready = state_reg == uipp_pkg::ST_IDLE;
        ps_we         = 1'b0;
        ps_waddr      = lp_reg;
        ps_wdata      = {cnt_new, first_new, amt_reg};
        pl_we         = 1'b0;
        pl_wdata      = {best_reg, best_fill_reg};
        sl_we         = 1'b0;
        sl_waddr      = km1[SW-1:0];
        sl_wdata      = {aged, sd_v, sd_fill, sd_hb};
        sl_raddr      = k_reg[SW-1:0];
        div_load      = 1'b0;
        div_dividend  = DN'(in_page);
        div_divisor   = DVW'(LOGICAL_PAGES);
        case (state_reg)
            uipp_pkg::ST_CLEAR:
            begin
                ps_we    = clr_reg < CLW'(LOGICAL_PAGES);
                ps_waddr = clr_reg[PW-1:0];
                ps_wdata = '0;
                sl_we    = clr_reg < CLW'(SLOTS);
                sl_waddr = clr_reg[SW-1:0];
                sl_wdata = '0;
            end
            uipp_pkg::ST_IDLE:
            begin
                div_load = in_acc && (in_op == uipp_pkg::OP_WRITE);
                sl_we    = in_acc && (in_op == uipp_pkg::OP_RELEASE) && rs_ok;
                sl_waddr = in_rs_w[SW-1:0];
                sl_wdata = '0;
            end
            uipp_pkg::ST_FULL:
            begin
                div_load     = 1'b1;
                div_dividend = DN'(TW'(span) << FRACTION_BITS);
                div_divisor  = DVW'(cnt_old_reg);
            end
            uipp_pkg::ST_SCAN:
            begin
                sl_we = k_reg != '0;
            end
            uipp_pkg::ST_P_RD:
            begin
                sl_raddr = prev_slot_reg;
            end
            uipp_pkg::ST_P_CMP:
            begin
                div_load     = 1'b1;
                div_dividend = DN'(prod_reg - PRW'(amt_reg));
                div_divisor  = DVW'(ent_v_reg - 1'b1);
            end
            uipp_pkg::ST_P_WR:
            begin
                sl_we    = 1'b1;
                sl_waddr = prev_slot_reg;
                sl_wdata = {pe_new, (ent_v_reg == '0) ? ent_v_reg : ent_v_reg - 1'b1,
                            ent_fill_reg, ent_hb_reg};
            end
            uipp_pkg::ST_A_RD:
            begin
                sl_raddr = best_reg;
            end
            uipp_pkg::ST_A_SUM:
            begin
                div_load     = 1'b1;
                div_dividend = DN'(prod_reg) + DN'(amt_reg);
                div_divisor  = DVW'(ent_v_reg) + 1'b1;
            end
            uipp_pkg::ST_A_WR:
            begin
                ps_we    = 1'b1;
                pl_we    = 1'b1;
                sl_we    = 1'b1;
                sl_waddr = best_reg;
                sl_wdata = {pe_new, (ent_v_reg < VMAX_F) ? ent_v_reg + 1'b1 : ent_v_reg,
                            ent_fill_reg + 1'b1, 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uipp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == uipp_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == uipp_pkg::ST_A_WR)
            begin
                last_time_reg <= now_reg;
            end
            if ((state_reg == uipp_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            dq_reg   <= div_dividend;
            drem_reg <= '0;
            ddiv_reg <= div_divisor;
            dcnt_reg <= '0;
        end
        else if (div_run)
        begin
            dq_reg   <= {dq_reg[DN-2:0], div_ge};
            drem_reg <= div_ge ? DVW'(div_trial - {1'b0, ddiv_reg}) : div_trial[DVW-1:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        case (state_reg)
            uipp_pkg::ST_IDLE:
            begin
                now_reg <= in_now;
                lp_reg  <= PW'(in_page);
                if (in_acc && (in_op == uipp_pkg::OP_RELEASE))
                begin
                    res_status_reg   <= uipp_pkg::STAT_RELEASED;
                    res_slot_reg     <= '0;
                    res_off_reg      <= '0;
                    res_need_reg     <= 1'b0;
                    res_old_v_reg    <= 1'b0;
                    res_old_slot_reg <= '0;
                    res_old_off_reg  <= '0;
                end
            end
            uipp_pkg::ST_MOD_FIN:
            begin
                lp_reg <= PW'(drem_reg);
            end
            uipp_pkg::ST_PAGE_RD:
            begin
                k_reg   <= '0;
                any_reg <= 1'b0;
            end
            uipp_pkg::ST_FULL:
            begin
                cnt_old_reg   <= ps_rdata[PSW-1:TW+32];
                first_reg     <= ps_rdata[TW+31:TW];
                amt_reg       <= ps_rdata[TW-1:0];
                prev_slot_reg <= pl_rdata[LCW-1:FW];
                prev_off_reg  <= pl_rdata[FW-1:0];
                gap_reg       <= TW'(elapsed) << FRACTION_BITS;
                k_reg         <= k_reg + 1'b1;
                if ((k_reg != '0) && sd_open)
                begin
                    any_reg <= 1'b1;
                end
                if (k_reg == (SW + 1)'(SLOTS))
                begin
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    if (!(any_reg || sd_open))
                    begin
                        res_status_reg   <= uipp_pkg::STAT_NO_ROOM;
                        res_slot_reg     <= '0;
                        res_off_reg      <= '0;
                        res_need_reg     <= 1'b0;
                        res_old_v_reg    <= 1'b0;
                        res_old_slot_reg <= '0;
                        res_old_off_reg  <= '0;
                    end
                end
            end
            uipp_pkg::ST_AVG_FIN:
            begin
                amt_reg <= dq_sat;
            end
            uipp_pkg::ST_SCAN:
            begin
                k_reg <= k_reg + 1'b1;
                // The first open slot wins ties because only a strictly smaller
                // distance replaces the current best.
                if ((k_reg != '0) && sd_open && (!found_reg || (slot_dist < best_d_reg)))
                begin
                    found_reg     <= 1'b1;
                    best_reg      <= km1[SW-1:0];
                    best_d_reg    <= slot_dist;
                    best_fill_reg <= sd_fill;
                    best_hb_reg   <= sd_hb;
                end
            end
            uipp_pkg::ST_P_WAIT:
            begin
                ent_e_reg    <= sd_e;
                ent_v_reg    <= sd_v;
                ent_fill_reg <= sd_fill;
                ent_hb_reg   <= sd_hb;
                pe_reg       <= (cnt_old_reg > CW'(1)) ? '0 : sd_e;
                use_div_reg  <= 1'b0;
            end
            uipp_pkg::ST_P_MUL:
            begin
                prod_reg <= PRW'(ent_e_reg) * PRW'(ent_v_reg);
            end
            uipp_pkg::ST_P_CMP:
            begin
                use_div_reg <= prod_reg >= PRW'(amt_reg);
            end
            uipp_pkg::ST_A_WAIT:
            begin
                ent_e_reg    <= sd_e;
                ent_v_reg    <= sd_v;
                ent_fill_reg <= sd_fill;
                ent_hb_reg   <= sd_hb;
                pe_reg       <= sd_e;
                use_div_reg  <= 1'b0;
            end
            uipp_pkg::ST_A_MUL:
            begin
                prod_reg <= PRW'(ent_e_reg) * PRW'(ent_v_reg);
            end
            uipp_pkg::ST_A_SUM:
            begin
                use_div_reg <= 1'b1;
            end
            uipp_pkg::ST_A_WR:
            begin
                res_status_reg   <= uipp_pkg::STAT_PLACED;
                res_slot_reg     <= 6'(best_reg);
                res_off_reg      <= 6'(best_fill_reg);
                res_need_reg     <= !best_hb_reg;
                res_old_v_reg    <= cnt_old_reg != '0;
                res_old_slot_reg <= (cnt_old_reg != '0) ? 6'(prev_slot_reg) : 6'd0;
                res_old_off_reg  <= (cnt_old_reg != '0) ? 6'(prev_off_reg) : 6'd0;
            end
            uipp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_status_reg <= res_status_reg;
                    out_data_reg   <= {res_old_off_reg, res_old_slot_reg, res_old_v_reg,
                                       res_need_reg, res_off_reg, res_slot_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

endmodule

// ===== rtl/uipp_checker.sv =====
// Port-level checker for the write placement engine and its bind to the top level.
module uipp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic [1:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Words accepted whose result has not been taken yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (pending_reg != 2'd0))
        else $error("result word without an accepted input word");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two words in flight");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken again before the word was processed");

endmodule

bind update_interval_page_placement_core uipp_checker u_uipp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
